// File: sv/smp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions for the seeded byte mutation picker.
// No dependencies; the picker modules and the testbench import this package.
package smp_pkg;

  // Generator constants
  localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;
  localparam logic [31:0] MT_UPPER    = 32'h8000_0000;
  localparam logic [31:0] MT_LOWER    = 32'h7fff_ffff;
  localparam logic [31:0] MT_MATRIX   = 32'h9908_b0df;
  localparam int          MT_M        = 397;

  // Seeding step counter: runs from 1 to the last word that a draw needs
  localparam int STEP_W = 9;
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_TAP1  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_TAP2  = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_TAP3  = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_FAR0  = STEP_W'(MT_M);
  localparam logic [STEP_W-1:0] STEP_FAR1  = STEP_W'(MT_M + 1);
  localparam logic [STEP_W-1:0] STEP_FAR2  = STEP_W'(MT_M + 2);

  // Field widths
  localparam int LEN_W   = 13;
  localparam int INDEX_W = 12;
  localparam int BYTE_W  = 8;

  // Remainder unit
  localparam int DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(31);

  // Operand values of the set kinds
  localparam logic [BYTE_W-1:0] OP_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] OP_FF   = 8'hFF;
  localparam logic [BYTE_W-1:0] OP_HALF = 8'h80;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_FLIP = 3'd0,
    KIND_SWAP = 3'd1,
    KIND_ZERO = 3'd2,
    KIND_FF   = 3'd3,
    KIND_HALF = 3'd4,
    KIND_NONE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEED,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_IDX,
    B_PART,
    B_DONE
  } back_state_t;

  // One classified request: the three draws and the clamped length
  typedef struct packed {
    logic             empty;
    logic [LEN_W-1:0] len;
    logic [31:0]      d0;
    logic [31:0]      d1;
    logic [31:0]      d2;
  } draw_entry_t;

  function automatic logic [31:0] mt_temper(input logic [31:0] x);
    logic [31:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c_5680);
    y = y ^ ((y << 15) & 32'hefc6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Twist one word from words i, i+1 and i+397, then temper it
  function automatic logic [31:0] mt_draw(input logic [31:0] wi,
                                          input logic [31:0] wn,
                                          input logic [31:0] wf);
    logic [31:0] y;
    logic [31:0] v;
    y = (wi & MT_UPPER) | (wn & MT_LOWER);
    v = wf ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
    return mt_temper(v);
  endfunction

  // Remainder by five: sixteen leaves one over five, so the nibble sum keeps
  // the residue; fold the sum once more, then strip whole fives
  function automatic logic [2:0] rem_by_five(input logic [31:0] x);
    logic [6:0] sum;
    logic [4:0] fold;
    logic [4:0] r;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 7'(x[4*i +: 4]);
    end
    fold = 5'(sum[6:4]) + 5'(sum[3:0]);
    if (fold >= 5'd20)      r = fold - 5'd20;
    else if (fold >= 5'd15) r = fold - 5'd15;
    else if (fold >= 5'd10) r = fold - 5'd10;
    else if (fold >= 5'd5)  r = fold - 5'd5;
    else                    r = fold;
    return r[2:0];
  endfunction

endpackage

// File: sv/smp_req_if.sv
`timescale 1ns / 1ps
// Request channel: seed and buffer length with valid/ready handshake.
// Depends on nothing.
interface smp_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;
  logic [12:0] buffer_length;

  modport source (output valid, output seed, output buffer_length, input ready);
  modport sink   (input valid, input seed, input buffer_length, output ready);
endinterface

// File: sv/smp_res_if.sv
`timescale 1ns / 1ps
// Result channel: mutation descriptor with valid/ready handshake.
// Depends on nothing.
interface smp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [11:0] byte_index;
  logic [7:0]  operand_byte;
  logic [11:0] swap_index;

  modport source (output valid, output kind, output byte_index, output operand_byte,
                  output swap_index, input ready);
  modport sink   (input valid, input kind, input byte_index, input operand_byte,
                  input swap_index, output ready);
endinterface

// File: sv/seeded_byte_mutation_picker.sv
`timescale 1ns / 1ps
// Seeded byte mutation picker, top level.
// Depends on smp_pkg, smp_req_if, smp_res_if, smp_front, smp_queue, smp_back.
//
// A request (seed, buffer_length) enters on req; one descriptor (kind,
// byte_index, operand_byte, swap_index) leaves on res for every request.
// Both channels move a request when valid and ready are high at a clock edge.
// The front seeds the generator one word per cycle through a single 32x32
// multiplier; a zero length skips seeding. The front takes a new request
// only after it has handed the last one on, and can seed it while the back
// still works on an earlier one. The back folds the first draw into the kind
// as it takes the request, then reduces the index and, for a swap of two or
// more bytes, the partner with a bit-serial remainder unit.
// A two-entry queue parts front and back, and the result sits in an output
// register: while the receiver stalls, the back holds its finished result,
// the queue fills and the front keeps seeding until the queue is full.
// Reset (rst, synchronous) empties the queue and drops any request in flight.
module seeded_byte_mutation_picker #(
  parameter int MAX_BUFFER_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst,
  smp_req_if.sink   req,
  smp_res_if.source res
);
  import smp_pkg::*;

  logic        push_valid, push_ready;
  logic        pop_valid, pop_ready;
  draw_entry_t push_entry, pop_entry;

  smp_front #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  smp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  smp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .res       (res)
  );

endmodule

// File: sv/smp_front.sv
`timescale 1ns / 1ps
// Front part: accepts a request, seeds the generator one word per cycle and
// forms the first three draws. Depends on smp_pkg and smp_req_if.
module smp_front #(
  parameter int MAX_BUFFER_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  smp_req_if.sink             req,
  output logic                push_valid,
  input  logic                push_ready,
  output smp_pkg::draw_entry_t push_entry
);
  import smp_pkg::*;

  front_state_t      state, state_next;
  logic [31:0]       word;
  logic [STEP_W-1:0] step;
  logic [31:0]       w0, w1, w2, w3, wf0, wf1, wf2;
  logic [LEN_W-1:0]  len;
  logic              empty;

  logic [LEN_W-1:0]  len_sat;
  logic [31:0]       word_next;
  logic              accept;

  // Clamp the length to the buffer limit
  assign len_sat = (32'(req.buffer_length) > 32'(MAX_BUFFER_BYTES)) ?
                   LEN_W'(MAX_BUFFER_BYTES) : req.buffer_length;

  // One initialisation step of the generator
  assign word_next = MT_INIT_MUL * (word ^ (word >> 30)) + 32'(step);

  assign req.ready = (state == F_IDLE);
  assign accept    = req.valid && req.ready;

  // Next state and queue push
  always_comb begin
    state_next = state;
    push_valid = 1'b0;
    case (state)
      F_IDLE: begin
        if (req.valid) begin
          state_next = (len_sat == '0) ? F_PUSH : F_SEED;
        end
      end
      F_SEED: begin
        if (step == STEP_FAR2) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Seed chain; keep only the words that the first three draws read
  always_ff @(posedge clk) begin
    if (accept) begin
      len   <= len_sat;
      empty <= (len_sat == '0);
      word  <= req.seed;
      w0    <= req.seed;
      step  <= STEP_FIRST;
    end else if (state == F_SEED) begin
      word <= word_next;
      step <= step + STEP_W'(1);
      if (step == STEP_TAP1) w1 <= word_next;
      if (step == STEP_TAP2) w2 <= word_next;
      if (step == STEP_TAP3) w3 <= word_next;
      if (step == STEP_FAR0) wf0 <= word_next;
      if (step == STEP_FAR1) wf1 <= word_next;
      if (step == STEP_FAR2) wf2 <= word_next;
    end
  end

  // Twist and temper the first three words
  always_comb begin
    push_entry.empty = empty;
    push_entry.len   = len;
    push_entry.d0    = mt_draw(w0, w1, wf0);
    push_entry.d1    = mt_draw(w1, w2, wf1);
    push_entry.d2    = mt_draw(w2, w3, wf2);
  end

endmodule

// File: sv/smp_queue.sv
`timescale 1ns / 1ps
// Short queue of classified requests between the front and back parts.
// Depends on smp_pkg.
module smp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  smp_pkg::draw_entry_t push_entry,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output smp_pkg::draw_entry_t pop_entry
);
  import smp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  draw_entry_t      mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store an entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: sv/smp_back.sv
`timescale 1ns / 1ps
// Back part: folds the first draw into the kind and reduces the other draws
// with a bit-serial remainder unit. Depends on smp_pkg and smp_res_if.
module smp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  smp_pkg::draw_entry_t pop_entry,
  smp_res_if.source            res
);
  import smp_pkg::*;

  back_state_t          state, state_next;
  draw_entry_t          ent;
  logic [31:0]          dividend;
  logic [LEN_W-1:0]     rem;
  logic [LEN_W-1:0]     divisor;
  logic [DIV_CNT_W-1:0] cnt;
  kind_t                kind_r, kind_o;
  logic [INDEX_W-1:0]   idx_r, part_r, idx_o, part_o;
  logic [BYTE_W-1:0]    op_r, op_o;
  logic                 out_valid;

  logic                 start_op;
  logic [31:0]          start_value;
  logic [LEN_W-1:0]     start_div;
  logic                 out_load;
  logic                 last;
  logic [LEN_W:0]       trial;
  logic [LEN_W-1:0]     rem_step;
  logic [BYTE_W-1:0]    op_sel;

  // One restoring remainder step per cycle, most significant bit first
  assign trial    = {rem, dividend[31]};
  assign rem_step = (trial >= {1'b0, divisor}) ?
                    LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
  assign last     = (cnt == DIV_CNT_LAST);

  // Operand byte for the kind just found
  always_comb begin
    case (kind_r)
      KIND_FLIP: op_sel = BYTE_W'(1) << ent.d2[2:0];
      KIND_ZERO: op_sel = OP_ZERO;
      KIND_FF:   op_sel = OP_FF;
      KIND_HALF: op_sel = OP_HALF;
      default:   op_sel = OP_ZERO;
    endcase
  end

  // Sequence the reductions
  always_comb begin
    state_next  = state;
    pop_ready   = 1'b0;
    start_op    = 1'b0;
    start_value = ent.d1;
    start_div   = ent.len;
    out_load    = 1'b0;
    case (state)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          if (pop_entry.empty) begin
            state_next = B_DONE;
          end else begin
            start_op    = 1'b1;
            start_value = pop_entry.d1;
            start_div   = pop_entry.len;
            state_next  = B_IDX;
          end
        end
      end
      B_IDX: begin
        if (last) begin
          if (kind_r == KIND_SWAP && ent.len >= LEN_W'(2)) begin
            start_op    = 1'b1;
            start_value = ent.d2;
            start_div   = ent.len;
            state_next  = B_PART;
          end else begin
            state_next = B_DONE;
          end
        end
      end
      B_PART: begin
        if (last) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid || res.ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Remainder unit
  always_ff @(posedge clk) begin
    if (start_op) begin
      dividend <= start_value;
      divisor  <= start_div;
      rem      <= '0;
      cnt      <= '0;
    end else begin
      dividend <= dividend << 1;
      rem      <= rem_step;
      cnt      <= cnt + DIV_CNT_W'(1);
    end
  end

  // Collect the descriptor fields
  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) begin
      ent <= pop_entry;
      if (pop_entry.empty) begin
        kind_r <= KIND_NONE;
        idx_r  <= '0;
        op_r   <= '0;
        part_r <= '0;
      end else begin
        kind_r <= kind_t'(rem_by_five(pop_entry.d0));
      end
    end
    if (state == B_IDX && last) begin
      idx_r  <= rem_step[INDEX_W-1:0];
      part_r <= rem_step[INDEX_W-1:0];
      op_r   <= op_sel;
    end
    if (state == B_PART && last) begin
      part_r <= rem_step[INDEX_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      kind_o <= kind_r;
      idx_o  <= idx_r;
      op_o   <= op_r;
      part_o <= part_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid        = out_valid;
  assign res.kind         = kind_o;
  assign res.byte_index   = idx_o;
  assign res.operand_byte = op_o;
  assign res.swap_index   = part_o;

endmodule

// File: tb/sv/tb_seeded_byte_mutation_picker.sv
`timescale 1ns / 1ps
// Self-checking testbench for seeded_byte_mutation_picker: checks every descriptor against an
// in-bench generator model, under random sender gaps and receiver stalls.
// Depends on smp_pkg, smp_req_if, smp_res_if and the picker RTL.
module tb_seeded_byte_mutation_picker;
  import smp_pkg::kind_t;
  import smp_pkg::KIND_FLIP;
  import smp_pkg::KIND_SWAP;
  import smp_pkg::KIND_ZERO;
  import smp_pkg::KIND_FF;
  import smp_pkg::KIND_HALF;
  import smp_pkg::KIND_NONE;

  localparam int MAX_BUFFER_BYTES = 4096;
  localparam int LONG_HOLD_CYCLES = 4000;
  localparam int SETTLE_CYCLES    = 700;
  localparam int REPORT_LIMIT     = 10;

  // Generator constants
  localparam logic [31:0] GEN_MUL    = 32'd1812433253;
  localparam logic [31:0] GEN_UPPER  = 32'h8000_0000;
  localparam logic [31:0] GEN_LOWER  = 32'h7fff_ffff;
  localparam logic [31:0] GEN_MATRIX = 32'h9908_b0df;
  localparam int          GEN_M      = 397;

  // Operand values of the set kinds
  localparam logic [7:0] SET_ZERO = 8'h00;
  localparam logic [7:0] SET_FF   = 8'hFF;
  localparam logic [7:0] SET_HALF = 8'h80;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] byte_index;
    logic [7:0]  operand_byte;
    logic [11:0] swap_index;
  } descriptor_t;

  class mutation_scoreboard;
    descriptor_t pending_q[$];
    int requests;
    int checked;
    int mismatches;
    int empties;
    int oversized;
    int short_swaps;
    int kind_hits[6];

    // Seed the generator, draw three words and turn them into a descriptor
    static function descriptor_t pick_mutation(input logic [31:0] seed,
                                               input logic [12:0] length_in);
      logic [31:0] words [0:GEN_M + 2];
      logic [31:0] draws [0:2];
      logic [31:0] y;
      logic [31:0] v;
      logic [31:0] len;
      descriptor_t d;
      len = (length_in > MAX_BUFFER_BYTES) ? 32'(MAX_BUFFER_BYTES) : 32'(length_in);
      d.kind = KIND_NONE;
      d.byte_index = '0;
      d.operand_byte = '0;
      d.swap_index = '0;
      if (len == 0) return d;
      words[0] = seed;
      for (int i = 1; i <= GEN_M + 2; i++) begin
        words[i] = GEN_MUL * (words[i-1] ^ (words[i-1] >> 30)) + 32'(i);
      end
      // Twist and temper only the first three words
      for (int j = 0; j < 3; j++) begin
        y = (words[j] & GEN_UPPER) | (words[j+1] & GEN_LOWER);
        v = words[j+GEN_M] ^ (y >> 1) ^ (y[0] ? GEN_MATRIX : 32'd0);
        v = v ^ (v >> 11);
        v = v ^ ((v << 7) & 32'h9d2c_5680);
        v = v ^ ((v << 15) & 32'hefc6_0000);
        v = v ^ (v >> 18);
        draws[j] = v;
      end
      d.kind = kind_t'(3'(draws[0] % 5));
      d.byte_index = 12'(draws[1] % len);
      d.swap_index = d.byte_index;
      case (d.kind)
        KIND_FLIP: d.operand_byte = 8'd1 << (draws[2] % 8);
        KIND_SWAP: begin
          if (len >= 2) d.swap_index = 12'(draws[2] % len);
        end
        KIND_ZERO: d.operand_byte = SET_ZERO;
        KIND_FF:   d.operand_byte = SET_FF;
        default:   d.operand_byte = SET_HALF;
      endcase
      return d;
    endfunction

    function void note_request(input logic [31:0] seed, input logic [12:0] len);
      descriptor_t d;
      d = pick_mutation(seed, len);
      pending_q.insert(pending_q.size(), d);
      requests++;
      if (len == 0) empties++;
      if (len > MAX_BUFFER_BYTES) oversized++;
      if (d.kind == KIND_SWAP && len < 2) short_swaps++;
    endfunction

    function void check_result(input logic [2:0] kind, input logic [11:0] byte_index,
                               input logic [7:0] operand_byte, input logic [11:0] swap_index);
      descriptor_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected descriptor: kind %0d idx %0d op %02h swap %0d",
                   kind, byte_index, operand_byte, swap_index);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (kind < 6) kind_hits[kind]++;
      if (kind !== want.kind || byte_index !== want.byte_index ||
          operand_byte !== want.operand_byte || swap_index !== want.swap_index) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("descriptor %0d wrong: expected kind %0d idx %0d op %02h swap %0d, got kind %0d idx %0d op %02h swap %0d",
                   checked, want.kind, want.byte_index, want.operand_byte, want.swap_index,
                   kind, byte_index, operand_byte, swap_index);
      end
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   long_hold_pending;

  smp_req_if req_ch ();
  smp_res_if res_ch ();

  mutation_scoreboard sb = new();

  seeded_byte_mutation_picker #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check every descriptor that the receiver takes
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.kind, res_ch.byte_index, res_ch.operand_byte, res_ch.swap_index);
  end

  // Receiver: stall on a pattern of its own, with one long hold on demand
  initial begin
    int stretch;
    int mode;
    logic [7:0] pat;
    stretch = 0;
    mode = 0;
    pat = '0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_pending = 1'b0;
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 9);
          stretch = $urandom_range(16, 256);
          pat = $urandom;
        end
        stretch--;
        if (mode < 4)
          res_ch.ready <= 1'b1;
        else if (mode < 7)
          res_ch.ready <= $urandom_range(0, 1);
        else
          res_ch.ready <= pat[stretch % 8];
      end
    end
  end

  // Offer one request and hold it until the block takes it
  task automatic offer_request(input logic [31:0] seed, input logic [12:0] len);
    req_ch.valid <= 1'b1;
    req_ch.seed <= seed;
    req_ch.buffer_length <= len;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(seed, len);
  endtask

  // Stop offering until every expected descriptor has come back
  task automatic drain_picker();
    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [12:0] random_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)  return 13'd0;
    if (pick < 15) return 13'($urandom_range(1, 2));
    if (pick < 55) return 13'($urandom_range(1, 64));
    if (pick < 78) return 13'($urandom_range(65, MAX_BUFFER_BYTES - 1));
    if (pick < 86) return 13'(MAX_BUFFER_BYTES);
    if (pick < 94) return 13'($urandom_range(MAX_BUFFER_BYTES + 1, 8191));
    return 13'($urandom_range(1, MAX_BUFFER_BYTES));
  endfunction

  function automatic logic [31:0] random_seed();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hffff_ffff;
    if (pick == 2) return 32'($urandom_range(0, 255));
    return $urandom;
  endfunction

  // Send random requests in bursts with random gaps between them
  task automatic send_random(input int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      for (int j = 0; j < burst && sent < count; j++) begin
        offer_request(random_seed(), random_length());
        sent++;
      end
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 500) : $urandom_range(0, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stimulus and end of run
  initial begin
    logic [31:0] kind_seed [0:4];
    bit found [0:4];
    int nfound;
    descriptor_t d;
    logic [31:0] s;
    rst = 1'b1;
    long_hold_pending = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.seed = '0;
    req_ch.buffer_length = '0;

    // Find one seed for each mutation kind
    nfound = 0;
    s = 32'd1;
    for (int k = 0; k < 5; k++) found[k] = 1'b0;
    while (nfound < 5) begin
      d = mutation_scoreboard::pick_mutation(s, 13'd1000);
      if (!found[d.kind]) begin
        found[d.kind] = 1'b1;
        kind_seed[d.kind] = s;
        nfound++;
      end
      s++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty buffers, extreme seeds and lengths, every kind, short swaps
    offer_request(32'h0000_0000, 13'd0);
    offer_request(32'hffff_ffff, 13'd0);
    offer_request(32'h0000_0000, 13'd1);
    offer_request(32'hffff_ffff, 13'(MAX_BUFFER_BYTES));
    offer_request(32'd5489, 13'(MAX_BUFFER_BYTES));
    offer_request(32'h1234_5678, 13'(MAX_BUFFER_BYTES + 1));
    offer_request(32'hdead_beef, 13'h1fff);
    offer_request(32'h8000_0000, 13'h0fff);
    for (int k = 0; k < 5; k++) begin
      offer_request(kind_seed[k], 13'd37);
      offer_request(kind_seed[k], 13'h1fff);
    end
    offer_request(kind_seed[KIND_SWAP], 13'd1);
    offer_request(kind_seed[KIND_SWAP], 13'd2);
    offer_request(kind_seed[KIND_FLIP], 13'd1);
    drain_picker();

    // Random, with one long receiver hold while requests keep coming
    send_random(200);
    long_hold_pending = 1'b1;
    send_random(150);
    drain_picker();
    send_random(180);
    drain_picker();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d of %0d requests: %0d empty, %0d oversized lengths, %0d short swaps",
             sb.checked, sb.requests, sb.empties, sb.oversized, sb.short_swaps);
    $display("kinds seen: flip %0d, swap %0d, set 00 %0d, set FF %0d, set 80 %0d, none %0d",
             sb.kind_hits[0], sb.kind_hits[1], sb.kind_hits[2], sb.kind_hits[3],
             sb.kind_hits[4], sb.kind_hits[5]);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
